// ===== hdl/srlt_pkg.sv =====
`timescale 1ns / 1ps

package srlt_pkg;

	localparam int unsigned NumSegs = 6;
	localparam int unsigned SegIdxW = 3;

	localparam logic [SegIdxW-1:0] RegCs = 3'd1;
	localparam logic [SegIdxW-1:0] RegSs = 3'd2;

	// APB register map (index is paddr[2])
	localparam logic RegGdtBase = 1'b0;
	localparam logic RegLdtBase = 1'b1;

	localparam int unsigned OpW = 1;
	localparam logic [OpW-1:0] OpTranslate = 1'b0;
	localparam logic [OpW-1:0] OpLoad      = 1'b1;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NULL        = 3'd1,
		ST_CS_NOT_CODE = 3'd2,
		ST_UNREADABLE  = 3'd3,
		ST_SS_BAD      = 3'd4,
		ST_SYSTEM      = 3'd5,
		ST_BAD_REG     = 3'd6
	} status_t;

	// write port into the segment register file
	typedef struct packed {
		logic               en;
		logic [SegIdxW-1:0] idx;
		logic [15:0]        selector;
		logic [31:0]        base;
		logic [31:0]        limit;
		logic [11:0]        attr;
	} srlt_wr_t;

	// type rules; acc is the access byte (byte 5) of the descriptor
	function automatic status_t check_type(input logic [SegIdxW-1:0] seg, input logic [7:0] acc);
		logic is_cd;
		logic is_exec;
		logic rw;
		status_t st;
		is_cd   = acc[4];
		is_exec = acc[3];
		rw      = acc[1];
		if (seg == RegCs) begin
			st = (is_cd && is_exec) ? ST_OK : ST_CS_NOT_CODE;
		end else if (seg == RegSs) begin
			st = (is_cd && !is_exec && rw) ? ST_OK : ST_SS_BAD;
		end else if (!is_cd) begin
			st = ST_SYSTEM;
		end else if (is_exec && !rw) begin
			st = ST_UNREADABLE;
		end else begin
			st = ST_OK;
		end
		return st;
	endfunction

endpackage

// ===== hdl/srlt_seg_file.sv =====
`timescale 1ns / 1ps

module srlt_seg_file
	import srlt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  srlt_wr_t           wr,
	input  logic [SegIdxW-1:0] rd_idx,
	output logic [31:0]        rd_base,
	output logic [31:0]        rd_limit
);

	logic [15:0] selector_q [NumSegs];
	logic [31:0] base_q     [NumSegs];
	logic [31:0] limit_q    [NumSegs];
	logic [11:0] attr_q     [NumSegs];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumSegs; i++) begin
				selector_q[i] <= '0;
				base_q[i]     <= '0;
				limit_q[i]    <= '0;
				attr_q[i]     <= '0;
			end
		end else if (wr.en && (wr.idx < SegIdxW'(NumSegs))) begin
			selector_q[wr.idx] <= wr.selector;
			base_q[wr.idx]     <= wr.base;
			limit_q[wr.idx]    <= wr.limit;
			attr_q[wr.idx]     <= wr.attr;
		end
	end

	// out-of-range register numbers read as zero
	always_comb begin
		rd_base  = '0;
		rd_limit = '0;
		if (rd_idx < SegIdxW'(NumSegs)) begin
			rd_base  = base_q[rd_idx];
			rd_limit = limit_q[rd_idx];
		end
	end

endmodule

// ===== hdl/segment_register_load_and_translate_core.sv =====
`timescale 1ns / 1ps

// Protected-mode segment unit with six segment registers (ES, CS, SS, DS, FS, GS).
// Takes one transaction per clock on the slave stream and returns one result per
// transaction: an input register holds the item, the checks, descriptor decode
// and the base/offset adder sit between it and the result register, and the
// segment register file is written on the same edge that the result is registered,
// so a translate straight after a load sees the new base. Backpressure on the
// master side stalls both stages; the input side stays ready while the result
// register is free or being drained. gdt_base (0x0) and ldt_base (0x4) are to be
// written over APB only while the stream is idle; the block does not enforce this.
module segment_register_load_and_translate_core
	import srlt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // seg_reg[2:0], offset[34:3], selector[50:35],
	                                    // descriptor[114:51], zero pad[119:115]
	input  logic [0:0]   s_axis_tuser,  // opcode[0]
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata   // status[2:0], lin_addr[34:3],
	                                    // seg_limit[66:35], desc_addr[98:67], zero pad[103:99]
);

	logic [31:0] gdt_base_q;
	logic [31:0] ldt_base_q;

	logic               valid_s1;
	logic [OpW-1:0]     opcode_s1;
	logic [SegIdxW-1:0] seg_reg_s1;
	logic [31:0]        offset_s1;
	logic [15:0]        selector_s1;
	logic [63:0]        descriptor_s1;

	logic        valid_s2;
	status_t     status_s2;
	logic [31:0] linear_s2;
	logic [31:0] limit_s2;
	logic [31:0] daddr_s2;

	logic adv;
	logic take;

	srlt_wr_t    wr;
	logic [31:0] rd_base;
	logic [31:0] rd_limit;

	logic        reg_ok;
	logic        use_ldt;
	logic [12:0] sel_idx;
	logic [31:0] daddr;
	logic [19:0] raw_limit;
	logic [31:0] eff_limit;
	logic [31:0] desc_base;
	logic [7:0]  acc;
	status_t     status;
	logic [31:0] linear;
	logic [31:0] limit;

	// ---------------- APB ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gdt_base_q <= '0;
			ldt_base_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == RegLdtBase) begin
				ldt_base_q <= pwdata;
			end else begin
				gdt_base_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == RegGdtBase) ? gdt_base_q : ldt_base_q;

	// ---------------- handshake ----------------
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1     <= s_axis_tuser[0:0];
			seg_reg_s1    <= s_axis_tdata[2:0];
			offset_s1     <= s_axis_tdata[34:3];
			selector_s1   <= s_axis_tdata[50:35];
			descriptor_s1 <= s_axis_tdata[114:51];
		end
	end

	// ---------------- decode and checks ----------------
	assign reg_ok  = seg_reg_s1 < SegIdxW'(NumSegs);
	assign use_ldt = selector_s1[2];
	assign sel_idx = selector_s1[15:3];
	assign daddr   = (use_ldt ? ldt_base_q : gdt_base_q) + {16'd0, sel_idx, 3'd0};

	assign acc       = descriptor_s1[47:40];
	assign raw_limit = {descriptor_s1[51:48], descriptor_s1[15:0]};
	// granularity bit scales the limit to 4 KiB pages
	assign eff_limit = descriptor_s1[55] ? {raw_limit, 12'hFFF} : {12'd0, raw_limit};
	assign desc_base = {descriptor_s1[63:56], descriptor_s1[39:16]};

	always_comb begin
		status = ST_OK;
		linear = '0;
		limit  = '0;
		if (!reg_ok) begin
			status = ST_BAD_REG;
		end else if (opcode_s1 == OpTranslate) begin
			linear = rd_base + offset_s1;
			limit  = rd_limit;
		end else begin
			if (!use_ldt && (sel_idx == '0)) begin
				status = ST_NULL;
			end else begin
				status = check_type(seg_reg_s1, acc);
			end
			limit = (status == ST_OK) ? eff_limit : rd_limit;
		end
	end

	always_comb begin
		wr.en       = adv && (opcode_s1 == OpLoad) && reg_ok && (status == ST_OK);
		wr.idx      = seg_reg_s1;
		wr.selector = selector_s1;
		wr.base     = desc_base;
		wr.limit    = eff_limit;
		wr.attr     = {descriptor_s1[55:52], acc};
	end

	srlt_seg_file u_seg_file (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_idx   (seg_reg_s1),
		.rd_base  (rd_base),
		.rd_limit (rd_limit)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status;
			linear_s2 <= linear;
			limit_s2  <= limit;
			daddr_s2  <= (opcode_s1 == OpLoad) ? daddr : 32'd0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, daddr_s2, limit_s2, linear_s2, status_s2};

endmodule

// ===== hdl/srlt_checker.sv =====
`timescale 1ns / 1ps

module srlt_checker
	import srlt_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input side only backs off when a result is waiting
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
		else $error("undefined status code");

	// failures only come from loads or bad registers, neither gives a linear address
	a_fail_no_linear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK) |-> m_axis_tdata[34:3] == 32'd0)
		else $error("linear address on failed transaction");

	a_bad_reg_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == ST_BAD_REG) |-> m_axis_tdata[66:35] == 32'd0)
		else $error("limit reported for bad register");

endmodule

bind segment_register_load_and_translate_core srlt_checker u_srlt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_segment_register_load_and_translate_core.sv =====
`timescale 1ns / 1ps

module tb_segment_register_load_and_translate_core;
	import srlt_pkg::*;

	localparam int WatchdogLimit = 5000;
	localparam int EndDrainCycles = 20;

	// segment register numbers not given by the package
	localparam logic [2:0] SegEs = 3'd0;
	localparam logic [2:0] SegDs = 3'd3;
	localparam logic [2:0] SegFs = 3'd4;
	localparam logic [2:0] SegGs = 3'd5;
	localparam logic [2:0] SegBadLo = 3'd6;
	localparam logic [2:0] SegBadHi = 3'd7;

	// access bytes (present, DPL 0)
	localparam logic [7:0] AccDataRw = 8'h92;
	localparam logic [7:0] AccDataRo = 8'h90;
	localparam logic [7:0] AccCodeR = 8'h9A;
	localparam logic [7:0] AccCodeXo = 8'h98;
	localparam logic [7:0] AccSystem = 8'h89;
	localparam logic [7:0] TypeMask = 8'h1A;  // S, E and R/W bits
	localparam logic [3:0] FlagG = 4'h8;
	localparam logic [3:0] FlagNone = 4'h0;

	typedef struct {
		status_t     status;
		logic [31:0] lin_addr;
		logic [31:0] seg_limit;
		logic [31:0] desc_addr;
	} seg_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;  // seg_reg, offset, selector, descriptor, pad
	logic [0:0]   s_axis_tuser = '0;  // opcode
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;       // status, lin_addr, seg_limit, desc_addr, pad

	segment_register_load_and_translate_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the segment registers and table bases
	logic [15:0] shadow_sel [NumSegs];
	logic [31:0] shadow_base [NumSegs];
	logic [31:0] shadow_limit [NumSegs];
	logic [11:0] shadow_attr [NumSegs];
	logic [31:0] gdt_base_cfg;
	logic [31:0] ldt_base_cfg;

	seg_result_t pending_results [$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_token = 0;
	int hold_len = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	function automatic seg_result_t apply_segment_item(logic [OpW-1:0] op, logic [2:0] seg,
			logic [31:0] offset, logic [15:0] selector, logic [63:0] desc);
		seg_result_t r;
		logic [7:0]  acc;
		logic [7:0]  b6;
		logic [12:0] idx;
		logic        ldt;
		logic [19:0] raw;
		r.status = ST_OK;
		r.lin_addr = '0;
		r.seg_limit = '0;
		r.desc_addr = '0;
		if (op == OpTranslate) begin
			if (seg >= NumSegs) begin
				r.status = ST_BAD_REG;
			end else begin
				r.lin_addr = shadow_base[seg] + offset;
				r.seg_limit = shadow_limit[seg];
			end
		end else begin
			idx = selector[15:3];
			ldt = selector[2];
			r.desc_addr = (ldt ? ldt_base_cfg : gdt_base_cfg) + {16'd0, idx, 3'b000};
			if (seg >= NumSegs) begin
				r.status = ST_BAD_REG;
			end else begin
				acc = desc[47:40];
				b6 = desc[55:48];
				if (!ldt && idx == 0)
					r.status = ST_NULL;
				else if (seg == RegCs)
					r.status = (acc[4] && acc[3]) ? ST_OK : ST_CS_NOT_CODE;
				else if (seg == RegSs)
					r.status = (acc[4] && !acc[3] && acc[1]) ? ST_OK : ST_SS_BAD;
				else if (!acc[4])
					r.status = ST_SYSTEM;
				else if (acc[3] && !acc[1])
					r.status = ST_UNREADABLE;
				if (r.status == ST_OK) begin
					raw = {b6[3:0], desc[15:0]};
					shadow_sel[seg] = selector;
					shadow_base[seg] = {desc[63:56], desc[39:16]};
					shadow_limit[seg] = b6[7] ? {raw, 12'hFFF} : {12'd0, raw};
					shadow_attr[seg] = {b6[7:4], acc};
				end
				r.seg_limit = shadow_limit[seg];
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] make_desc(logic [31:0] base, logic [19:0] lim,
			logic [7:0] acc, logic [3:0] flags);
		return {base[31:24], flags, lim[19:16], acc, base[23:0], lim[15:0]};
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(logic [OpW-1:0] op, logic [2:0] seg, logic [31:0] offset,
			logic [15:0] selector, logic [63:0] desc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, desc, selector, offset, seg};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_segment_item(op, seg, offset, selector, desc));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// write a table base, then read it back
	task automatic config_write(logic idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == RegGdtBase)
			gdt_base_cfg = value;
		else
			ldt_base_cfg = value;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("prdata mismatch: expected %h, got %h", value, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_tables(logic [31:0] gdt, logic [31:0] ldt);
		config_write(RegGdtBase, gdt);
		config_write(RegLdtBase, ldt);
	endtask

	task automatic send_random_item();
		logic [OpW-1:0] op;
		logic [2:0]     seg;
		logic [31:0]    offset;
		logic [15:0]    selector;
		logic [63:0]    desc;
		logic [7:0]     type_bits;
		op = OpW'($urandom_range(1));
		seg = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
		case ($urandom_range(9))
			0: offset = '0;
			1: offset = '1;
			default: offset = $urandom;
		endcase
		selector = 16'($urandom);
		if ($urandom_range(7) == 0)
			selector[15:2] = '0;  // null GDT selector, any RPL
		desc = {$urandom, $urandom};
		case ($urandom_range(5))
			0: type_bits = AccDataRw & TypeMask;
			1: type_bits = AccDataRo & TypeMask;
			2: type_bits = AccCodeR & TypeMask;
			3: type_bits = AccCodeXo & TypeMask;
			4: type_bits = 8'($urandom) & TypeMask & ~8'h10;  // system
			default: type_bits = desc[47:40] & TypeMask;
		endcase
		desc[47:40] = (desc[47:40] & ~TypeMask) | type_bits;
		send_item(op, seg, offset, selector, desc);
	endtask

	task automatic run_random_items(int count);
		repeat (count) send_random_item();
		wait_drained();
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_tables(32'hFFFF_F000, 32'h0000_1000);
		send_item(OpTranslate, SegEs, 32'hFFFF_FFFF, '0, '0);
		send_item(OpTranslate, SegBadLo, 32'h1234_5678, '0, '0);
		send_item(OpTranslate, SegBadHi, 32'hFFFF_FFFF, '0, '0);
		send_item(OpLoad, SegBadHi, '0, 16'hFFFF, make_desc('1, '1, AccDataRw, FlagG));
		send_item(OpLoad, SegDs, '0, 16'h0003, make_desc(32'h1111_1111, '1, AccDataRw, FlagG));
		send_item(OpLoad, RegCs, '0, 16'h0000, make_desc('0, '1, AccCodeR, FlagNone));
		// LDT index 0 is not null
		send_item(OpLoad, SegDs, '0, 16'h0004,
			make_desc(32'h1234_5678, 20'hABCDE, AccDataRw, FlagNone));
		send_item(OpLoad, RegCs, '0, 16'h0008, make_desc('0, '1, AccDataRw, FlagNone));
		send_item(OpLoad, RegCs, '0, 16'h0010, make_desc('0, '1, AccSystem, FlagNone));
		send_item(OpLoad, RegCs, '0, 16'h0018,
			make_desc(32'hFFFF_FFF0, 20'hFFFFF, AccCodeXo, FlagG));
		send_item(OpTranslate, RegCs, 32'h0000_0020, '0, '0);  // wraps
		send_item(OpLoad, RegSs, '0, 16'h0020, make_desc('0, '1, AccCodeR, FlagNone));
		send_item(OpLoad, RegSs, '0, 16'h0028, make_desc('0, '1, AccDataRo, FlagNone));
		send_item(OpLoad, RegSs, '0, 16'h0030, make_desc('0, '1, AccSystem, FlagNone));
		send_item(OpLoad, RegSs, '0, 16'h0038, make_desc(32'h0000_8000, '0, AccDataRw, FlagG));
		send_item(OpLoad, SegEs, '0, 16'h0040, make_desc('1, '1, AccSystem, FlagG));
		send_item(OpLoad, SegEs, '0, 16'h0048, make_desc('1, '1, AccCodeXo, FlagG));
		send_item(OpTranslate, SegEs, 32'h0000_0100, '0, '0);  // failed loads kept ES
		send_item(OpLoad, SegFs, '0, 16'h0050, make_desc('0, '0, AccCodeR, FlagNone));
		send_item(OpLoad, SegGs, '0, 16'h005B, make_desc('1, 20'hFFFFF, AccDataRo, FlagNone));
		send_item(OpLoad, SegGs, '0, 16'hFFFC, make_desc('0, '0, AccSystem, FlagNone));
		send_item(OpLoad, SegDs, '0, 16'hFFFB, make_desc(32'h8000_0000, '1, AccDataRw, FlagG));
		send_item(OpTranslate, SegDs, '0, '0, '0);
		send_item(OpTranslate, SegGs, 32'hFFFF_FFFF, '0, '0);
		send_item(OpTranslate, SegFs, 32'h0000_0001, '0, '0);
		wait_drained();
	endtask

	task automatic test_streaming_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_tables('1, '1);
		run_random_items(400);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 85;
		recv_stall_pct = 0;
		set_tables('0, '0);
		run_random_items(400);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		recv_stall_pct = 85;
		set_tables($urandom, $urandom);
		run_random_items(400);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 32;
		recv_stall_pct = 32;
		set_tables($urandom, '1);
		run_random_items(400);
	endtask

	// long sink hold-off with the source still offering: pipeline fills, input stalls
	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 300;
		hold_token++;
		run_random_items(60);
	endtask

	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		seg_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[2:0] !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status,
						m_axis_tdata[2:0]);
					fail_count++;
				end
				if (m_axis_tdata[34:3] !== want.lin_addr) begin
					$error("lin_addr mismatch: expected %h, got %h", want.lin_addr,
						m_axis_tdata[34:3]);
					fail_count++;
				end
				if (m_axis_tdata[66:35] !== want.seg_limit) begin
					$error("seg_limit mismatch: expected %h, got %h", want.seg_limit,
						m_axis_tdata[66:35]);
					fail_count++;
				end
				if (m_axis_tdata[98:67] !== want.desc_addr) begin
					$error("desc_addr mismatch: expected %h, got %h", want.desc_addr,
						m_axis_tdata[98:67]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WatchdogLimit) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NumSegs; i++) begin
			shadow_sel[i] = '0;
			shadow_base[i] = '0;
			shadow_limit[i] = '0;
			shadow_attr[i] = '0;
		end
		gdt_base_cfg = '0;
		ldt_base_cfg = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_streaming_no_idle();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure_fill();

		recv_stall_pct = 0;
		repeat (EndDrainCycles) @(negedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
